>>> design/jbru_pkg.sv
// Package for the JPEG bit reader with byte unstuffing.
// Holds the request/result structs, command and status codes and defaults.
// No dependencies.
`default_nettype none

package jbru_pkg;

  // Default sizes
  localparam int BUFFER_BITS_DEF      = 32;
  localparam int MAX_REQUEST_BITS_DEF = 16;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 5;
  localparam int BITS_W  = 16;
  localparam int STAT_W  = 2;
  localparam int AVAIL_W = 6;

  // Stream constants
  localparam int              BYTE_BITS   = 8;
  localparam int              AVAIL_MAX   = 63;
  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] STUFF_BYTE  = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_GET   = 2'd1,
    CMD_ALIGN = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                 command;
    logic [BYTE_W-1:0]    byte_value;
    logic [COUNT_W-1:0]   bit_count;
  } in_item_t;

  typedef struct packed {
    logic [BITS_W-1:0]    bits_value;
    status_t              status;
    logic [AVAIL_W-1:0]   bits_available;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/jbru_core.sv
// Bit buffer state and the single-pass command datapath.
// Depends on jbru_pkg.
`default_nettype none

module jbru_core #(
  parameter int BUFFER_BITS      = jbru_pkg::BUFFER_BITS_DEF,
  parameter int MAX_REQUEST_BITS = jbru_pkg::MAX_REQUEST_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exec,
  input  jbru_pkg::in_item_t  item,
  output jbru_pkg::out_item_t result
);
  import jbru_pkg::*;

  localparam int FILL_W = $clog2(BUFFER_BITS + 1);
  localparam int EXT_W  = (FILL_W > 7) ? FILL_W : 7;

  logic [BUFFER_BITS-1:0] buf_r, buf_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic                   marker_r, marker_nxt;

  logic [COUNT_W-1:0]     n_req;
  logic [FILL_W-1:0]      shift_amt;
  logic [BUFFER_BITS-1:0] shifted;
  logic [BITS_W:0]        mask_w;
  logic                   no_room;
  logic [BITS_W-1:0]      value;
  status_t                status;
  logic [EXT_W-1:0]       fill_ext;

  // Clamp the request and line up the front bits
  assign n_req     = (item.bit_count > COUNT_W'(MAX_REQUEST_BITS)) ?
                     COUNT_W'(MAX_REQUEST_BITS) : item.bit_count;
  assign shift_amt = fill_r - FILL_W'(n_req);
  assign shifted   = buf_r >> shift_amt;
  assign mask_w    = ((BITS_W+1)'(1) << n_req) - (BITS_W+1)'(1);
  assign no_room   = ({1'b0, fill_r} + (FILL_W+1)'(BYTE_BITS)) > (FILL_W+1)'(BUFFER_BITS);

  // Decode the command and form next state and result
  always_comb begin
    buf_nxt    = buf_r;
    fill_nxt   = fill_r;
    marker_nxt = marker_r;
    value      = '0;
    status     = ST_OK;
    unique case (item.command)
      CMD_PUSH: begin
        if (marker_r && (item.byte_value == STUFF_BYTE)) begin
          // drop the stuffed zero
          marker_nxt = 1'b0;
        end else if (no_room) begin
          status = ST_FULL;
        end else begin
          buf_nxt    = {buf_r[BUFFER_BITS-BYTE_BITS-1:0], item.byte_value};
          fill_nxt   = fill_r + FILL_W'(BYTE_BITS);
          marker_nxt = (item.byte_value == MARKER_BYTE);
        end
      end
      CMD_GET: begin
        if (n_req == '0) begin
          status = ST_OK;
        end else if (FILL_W'(n_req) > fill_r) begin
          status = ST_SHORT;
        end else begin
          value    = shifted[BITS_W-1:0] & mask_w[BITS_W-1:0];
          fill_nxt = shift_amt;
        end
      end
      CMD_ALIGN: begin
        fill_nxt = fill_r & ~FILL_W'(BYTE_BITS - 1);
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Saturate the reported fill
  assign fill_ext              = EXT_W'(fill_nxt);
  assign result.bits_value     = value;
  assign result.status         = status;
  assign result.bits_available = (fill_ext > EXT_W'(AVAIL_MAX)) ?
                                 AVAIL_W'(AVAIL_MAX) : fill_ext[AVAIL_W-1:0];

  // Hold state; advance on each executed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r    <= '0;
      fill_r   <= '0;
      marker_r <= 1'b0;
    end else if (exec) begin
      buf_r    <= buf_nxt;
      fill_r   <= fill_nxt;
      marker_r <= marker_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/jpeg_bit_reader_unstuff_unit.sv
// A request is held in the input register, then its result in the result register, where
// it can be taken. Throughput: one request per cycle while the output is not stalled;
// the fill/shift datapath runs in a single pass.
// The input register keeps accepting while a result waits, stalling only when both are full.
// Reset (rst_n low, synchronous) empties both registers and clears the bit buffer,
// fill count and marker flag.
`default_nettype none

module jpeg_bit_reader_unstuff_unit #(
  parameter int BUFFER_BITS      = jbru_pkg::BUFFER_BITS_DEF,
  parameter int MAX_REQUEST_BITS = jbru_pkg::MAX_REQUEST_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  jbru_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output jbru_pkg::out_item_t out_item
);
  import jbru_pkg::*;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_free;
  logic      exec;
  logic      in_take;

  // Handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign exec     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  jbru_core #(
    .BUFFER_BITS      (BUFFER_BITS),
    .MAX_REQUEST_BITS (MAX_REQUEST_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .exec   (exec),
    .item   (in_item_r),
    .result (result)
  );

  // Input register: hold while the result side is blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  // Result register: load on execute, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> design/jbru_checker.sv
// Port-level checks for the JPEG bit reader, bound to the top level.
// Depends on jbru_pkg and jpeg_bit_reader_unstuff_unit.
`default_nettype none

module jbru_checker #(
  parameter int BUFFER_BITS = jbru_pkg::BUFFER_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input jbru_pkg::out_item_t out_item
);
  import jbru_pkg::*;

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Shortfall returns no bits
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_SHORT) |-> out_item.bits_value == '0)
    else $error("shortfall with nonzero bits");

  // Dropped push only when a byte truly does not fit
  a_full_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL) |->
      (8'(out_item.bits_available) + 8'(BYTE_BITS)) > 8'(BUFFER_BITS))
    else $error("full status with room left");

  // Fill never exceeds the buffer size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 8'(out_item.bits_available) <= 8'(BUFFER_BITS))
    else $error("fill beyond buffer size");

endmodule

bind jpeg_bit_reader_unstuff_unit jbru_checker #(.BUFFER_BITS(BUFFER_BITS)) u_jbru_checker (.*);

`default_nettype wire

>>> bench/jpeg_bit_reader_unstuff_unit_tb.sv
// Self-checking bench for jpeg_bit_reader_unstuff_unit: pushes, gets and aligns
// are scored against a cycle-free mirror of the bit buffer. Depends on jbru_pkg.
`default_nettype none

module jpeg_bit_reader_unstuff_unit_tb;
  import jbru_pkg::*;

  localparam int BUF_BITS      = BUFFER_BITS_DEF;
  localparam int MAX_REQ_BITS  = MAX_REQUEST_BITS_DEF;
  localparam int IDLE_LIMIT    = 2000;
  localparam int ITEMS_PER_RUN = 233;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Pending stream commands and results still owed by the block
  in_item_t  stream_cmds[$];
  out_item_t due_results[$];

  // Mirror of the reader state
  logic [BUF_BITS-1:0] mirror_bits = '0;
  int                  mirror_fill = 0;
  logic                mirror_marker = 1'b0;

  int   sender_idle_pct = 36;
  int   recv_idle_pct = 83;
  int   error_count = 0;
  int   idle_cycles = 0;
  logic req_taken = 1'b0;
  logic last_pushed_ff = 1'b0;

  jpeg_bit_reader_unstuff_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic in_item_t make_req(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] val,
                                        logic [COUNT_W-1:0] count);
    in_item_t req;
    req.command    = cmd_t'(cmd);
    req.byte_value = val;
    req.bit_count  = count;
    return req;
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function automatic out_item_t next_reader_result(in_item_t req);
    out_item_t   res;
    int          n;
    int          avail;
    logic [63:0] window;
    res = '0;
    res.status = ST_OK;
    case (req.command)
      CMD_PUSH: begin
        if (mirror_marker && req.byte_value == STUFF_BYTE) begin
          mirror_marker = 1'b0;
        end else if (mirror_fill + BYTE_BITS > BUF_BITS) begin
          res.status = ST_FULL;
        end else begin
          mirror_bits   = (mirror_bits << BYTE_BITS) | BUF_BITS'(req.byte_value);
          mirror_fill   = mirror_fill + BYTE_BITS;
          mirror_marker = (req.byte_value == MARKER_BYTE);
        end
      end
      CMD_GET: begin
        n = (req.bit_count > MAX_REQ_BITS) ? MAX_REQ_BITS : int'(req.bit_count);
        if (n > mirror_fill) begin
          res.status = ST_SHORT;
        end else if (n != 0) begin
          window = 64'(mirror_bits);
          window = (window >> (mirror_fill - n)) & ((64'd1 << n) - 64'd1);
          res.bits_value = window[BITS_W-1:0];
          mirror_fill = mirror_fill - n;
        end
      end
      CMD_ALIGN: begin
        mirror_fill = (mirror_fill / BYTE_BITS) * BYTE_BITS;
      end
      default: ;
    endcase
    avail = (mirror_fill > AVAIL_MAX) ? AVAIL_MAX : mirror_fill;
    res.bits_available = avail[AVAIL_W-1:0];
    return res;
  endfunction

  // Queue mostly well-formed traffic: byte pushes with stuffing, gets, aligns
  task automatic add_random(int count);
    int                 pick;
    logic [BYTE_W-1:0]  val;
    logic [COUNT_W-1:0] bits;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      val  = BYTE_W'($urandom_range(0, 255));
      bits = COUNT_W'($urandom_range(0, 31));
      if (pick < 45) begin
        if (last_pushed_ff && $urandom_range(0, 9) < 7) begin
          val = STUFF_BYTE;
        end else if ($urandom_range(0, 99) < 15) begin
          val = MARKER_BYTE;
        end
        last_pushed_ff = (val == MARKER_BYTE);
        stream_cmds.push_back(make_req(CMD_PUSH, val, bits));
      end else if (pick < 85) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          bits = COUNT_W'($urandom_range(1, MAX_REQ_BITS));
        end else if (pick < 90) begin
          bits = '0;
        end else begin
          bits = COUNT_W'($urandom_range(MAX_REQ_BITS + 1, 31));
        end
        stream_cmds.push_back(make_req(CMD_GET, val, bits));
      end else if (pick < 95) begin
        stream_cmds.push_back(make_req(CMD_ALIGN, val, bits));
      end else begin
        stream_cmds.push_back(make_req(CMD_SPARE, val, bits));
      end
    end
  endtask

  // Directed opening: empty buffer, stuffing, full buffer, oversized and short gets
  task automatic add_directed();
    stream_cmds.push_back(make_req(CMD_GET,   8'h00, 5'd1));
    stream_cmds.push_back(make_req(CMD_GET,   8'hFF, 5'd0));
    stream_cmds.push_back(make_req(CMD_ALIGN, 8'h00, 5'd0));
    stream_cmds.push_back(make_req(CMD_SPARE, 8'hFF, 5'd31));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'hFF, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'h00, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'h00, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'hA5, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'hFF, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'h3C, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'h00, 5'd31));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'hFF, 5'd0));
    stream_cmds.push_back(make_req(CMD_GET,   8'hFF, 5'd31));
    stream_cmds.push_back(make_req(CMD_GET,   8'h00, 5'd3));
    stream_cmds.push_back(make_req(CMD_ALIGN, 8'hFF, 5'd31));
    stream_cmds.push_back(make_req(CMD_GET,   8'h00, 5'd16));
    stream_cmds.push_back(make_req(CMD_GET,   8'h00, 5'd8));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'hFF, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'hFF, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'h00, 5'd0));
    stream_cmds.push_back(make_req(CMD_PUSH,  8'h00, 5'd0));
    stream_cmds.push_back(make_req(CMD_GET,   8'h00, 5'd16));
    stream_cmds.push_back(make_req(CMD_GET,   8'h00, 5'd16));
    stream_cmds.push_back(make_req(CMD_GET,   8'h00, 5'd8));
    stream_cmds.push_back(make_req(CMD_ALIGN, 8'h00, 5'd0));
  endtask

  // Sequence reset, the three idling phases and the final drain
  initial begin
    add_directed();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 83 : 0;
      recv_idle_pct   = (phase == 0) ? 83 : (phase == 1) ? 36 : 0;
      add_random(ITEMS_PER_RUN);
      while (stream_cmds.size() != 0 || in_valid) @(posedge clk);
    end
    while (due_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("jpeg_bit_reader_unstuff_unit test passed");
    end else begin
      $display("jpeg_bit_reader_unstuff_unit test failed");
    end
    $finish;
  end

  // Drive requests: hold until taken, then advance or idle
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || req_taken) begin
        if (stream_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_item  <= stream_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Predict on accepted requests and score accepted results
  always @(posedge clk) begin : score_blk
    out_item_t want;
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due_results.push_back(next_reader_result(in_item));
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result value %h status %0d avail %0d", $time,
                   out_item.bits_value, out_item.status, out_item.bits_available);
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (out_item.bits_value !== want.bits_value || out_item.status !== want.status ||
              out_item.bits_available !== want.bits_available) begin
            $display({"%0t: mismatch value exp %h got %h, status exp %0d got %0d,",
                      " avail exp %0d got %0d"},
                     $time, want.bits_value, out_item.bits_value, want.status, out_item.status,
                     want.bits_available, out_item.bits_available);
            error_count++;
          end
        end
      end
    end
  end

  // Stop the run when no request moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("jpeg_bit_reader_unstuff_unit test failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
